// ===== hw/rtl/spmc_pkg.sv =====
`default_nettype none

package spmc_pkg;

    // Number of signal slots; usable signal numbers are 1 to NUM_SIGNALS-1.
    localparam int NUM_SIGNALS = 32;

    localparam int SIG_KILL_NO = 9;
    localparam int SIG_STOP_NO = 19;

    // Signals that can never be blocked or taken.
    localparam logic [31:0] FIXED_BITS = (32'd1 << SIG_KILL_NO) | (32'd1 << SIG_STOP_NO);
    // Bits that stand for usable signal numbers.
    localparam logic [31:0] VALID_BITS = 32'((64'd1 << NUM_SIGNALS) - 64'd2);

    localparam logic [31:0] ALLOWED_MASK_RESET = 32'hFFFF_FFFE;

    // Command codes.
    localparam logic [2:0] CMD_SEND       = 3'd0;
    localparam logic [2:0] CMD_DEQUEUE    = 3'd1;
    localparam logic [2:0] CMD_TAKE       = 3'd2;
    localparam logic [2:0] CMD_MODIFY     = 3'd3;
    localparam logic [2:0] CMD_ARM_WAIT   = 3'd4;
    localparam logic [2:0] CMD_CLEAR_ALL  = 3'd5;
    localparam logic [2:0] CMD_CLEAR_KEEP = 3'd6;

    // Mask operation codes.
    localparam logic [1:0] MOP_BLOCK   = 2'd0;
    localparam logic [1:0] MOP_UNBLOCK = 2'd1;
    localparam logic [1:0] MOP_SET     = 2'd2;

    // Status codes.
    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_INVALID = 1'b1;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [5:0]  signal_number;
        logic [31:0] mask_value;
        logic [1:0]  mask_op;
        logic        consume_flag;
        logic        task_sleeping;
    } t_in_item;

    typedef struct packed {
        logic        status;
        logic [5:0]  picked_signal;
        logic [31:0] previous_mask;
        logic        wake_request;
        logic        any_pending;
        logic        any_deliverable;
        logic        wait_done;
        logic [5:0]  wait_signal;
    } t_out_item;

    // Index of the lowest set bit above bit zero; zero when there is none.
    function automatic logic [5:0] lowest_signal(input logic [31:0] cand);
        logic [5:0] res;
        res = 6'd0;
        for (int i = 31; i >= 1; i--) begin
            if (cand[i]) begin
                res = 6'(i);
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/spmc_in_stage.sv =====
`default_nettype none

module spmc_in_stage (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire spmc_pkg::t_in_item i_item,
    input  wire logic              i_take,
    output logic                   o_valid,
    output spmc_pkg::t_in_item     o_item
);
    import spmc_pkg::*;

    logic     r_valid;
    t_in_item r_item;

    // The register can load whenever it is empty or its item leaves this cycle.
    assign o_stall = r_valid && !i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    // Payload captures on every transfer.
    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

// ===== hw/rtl/spmc_exec.sv =====
`default_nettype none

module spmc_exec (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [31:0]        i_cfg_wdata,
    input  wire logic               i_fire,
    input  wire spmc_pkg::t_in_item i_item,
    output spmc_pkg::t_out_item     o_result
);
    import spmc_pkg::*;

    logic [31:0] r_allowed_mask;
    logic [31:0] r_pending;
    logic [31:0] r_blocked;
    logic        r_wait_armed;
    logic [31:0] r_wait_set;
    logic        r_wait_consumes;
    logic        r_wait_ready;
    logic [5:0]  r_wait_signal;

    logic [31:0] n_pending;
    logic [31:0] n_blocked;
    logic        n_wait_armed;
    logic [31:0] n_wait_set;
    logic        n_wait_consumes;
    logic        n_wait_ready;
    logic [5:0]  n_wait_signal;

    logic        sig_ok;
    logic [31:0] sig_bit;
    logic [31:0] cand;
    logic [31:0] cand_low;
    logic [31:0] mod_mask;
    t_out_item   res;

    // Single-bit mask of the sent signal, zero when the number is unusable.
    assign sig_ok  = (i_item.signal_number != 6'd0)
                   && (32'(i_item.signal_number) < 32'(NUM_SIGNALS));
    assign sig_bit = sig_ok ? (32'd1 << i_item.signal_number[4:0]) : 32'd0;

    // Candidates for dequeue or take, and their lowest member as a one-hot mask.
    always_comb begin
        if (i_item.cmd == CMD_TAKE) begin
            cand = r_pending & i_item.mask_value & r_allowed_mask & ~FIXED_BITS & VALID_BITS;
        end else begin
            cand = r_pending & ~r_blocked & VALID_BITS;
        end
    end
    assign cand_low = cand & (~cand + 32'd1);
    assign mod_mask = i_item.mask_value & r_allowed_mask;

    // Next state and result of the current command.
    always_comb begin
        n_pending       = r_pending;
        n_blocked       = r_blocked;
        n_wait_armed    = r_wait_armed;
        n_wait_set      = r_wait_set;
        n_wait_consumes = r_wait_consumes;
        n_wait_ready    = r_wait_ready;
        n_wait_signal   = r_wait_signal;
        res             = '0;
        res.status      = STATUS_OK;

        case (i_item.cmd)
            CMD_SEND: begin
                if (!sig_ok) begin
                    res.status = STATUS_INVALID;
                end else if ((sig_bit & FIXED_BITS) != 32'd0) begin
                    n_pending        = r_pending | sig_bit;
                    res.wake_request = ((r_blocked & sig_bit) == 32'd0) && i_item.task_sleeping;
                end else if (r_wait_armed && ((r_wait_set & sig_bit) != 32'd0)) begin
                    n_wait_armed  = 1'b0;
                    n_wait_ready  = 1'b1;
                    n_wait_signal = i_item.signal_number;
                    if (!r_wait_consumes) begin
                        n_pending = r_pending | sig_bit;
                    end
                    res.wake_request = i_item.task_sleeping;
                end else begin
                    n_pending        = r_pending | sig_bit;
                    res.wake_request = ((r_blocked & sig_bit) == 32'd0) && i_item.task_sleeping;
                end
            end
            CMD_DEQUEUE, CMD_TAKE: begin
                res.picked_signal = lowest_signal(cand);
                n_pending         = r_pending & ~cand_low;
            end
            CMD_MODIFY: begin
                res.previous_mask = r_blocked;
                case (i_item.mask_op)
                    MOP_BLOCK:   n_blocked = (r_blocked | mod_mask) & ~FIXED_BITS;
                    MOP_UNBLOCK: n_blocked = (r_blocked & ~mod_mask) & ~FIXED_BITS;
                    MOP_SET:     n_blocked = mod_mask & ~FIXED_BITS;
                    default:     res.status = STATUS_INVALID;
                endcase
            end
            CMD_ARM_WAIT: begin
                n_wait_armed    = 1'b1;
                n_wait_set      = mod_mask;
                n_wait_consumes = i_item.consume_flag;
                n_wait_ready    = 1'b0;
                n_wait_signal   = 6'd0;
            end
            CMD_CLEAR_ALL, CMD_CLEAR_KEEP: begin
                n_pending       = 32'd0;
                n_blocked       = (i_item.cmd == CMD_CLEAR_ALL) ? 32'd0 : (r_blocked & ~FIXED_BITS);
                n_wait_armed    = 1'b0;
                n_wait_set      = 32'd0;
                n_wait_consumes = 1'b0;
                n_wait_ready    = 1'b0;
                n_wait_signal   = 6'd0;
            end
            default: begin
                res.status = STATUS_OK;
            end
        endcase

        // Summary flags reflect the state after the command.
        res.any_pending     = (n_pending != 32'd0);
        res.any_deliverable = ((n_pending & ~n_blocked & VALID_BITS) != 32'd0);
        res.wait_done       = n_wait_ready;
        res.wait_signal     = n_wait_signal;
    end

    assign o_result = res;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_allowed_mask <= ALLOWED_MASK_RESET;
        end else if (i_cfg_we) begin
            r_allowed_mask <= i_cfg_wdata;
        end
    end

    // Controller state advances once per executed item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending       <= 32'd0;
            r_blocked       <= 32'd0;
            r_wait_armed    <= 1'b0;
            r_wait_set      <= 32'd0;
            r_wait_consumes <= 1'b0;
            r_wait_ready    <= 1'b0;
            r_wait_signal   <= 6'd0;
        end else if (i_fire) begin
            r_pending       <= n_pending;
            r_blocked       <= n_blocked;
            r_wait_armed    <= n_wait_armed;
            r_wait_set      <= n_wait_set;
            r_wait_consumes <= n_wait_consumes;
            r_wait_ready    <= n_wait_ready;
            r_wait_signal   <= n_wait_signal;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/spmc_out_stage.sv =====
`default_nettype none

module spmc_out_stage (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_load,
    input  wire spmc_pkg::t_out_item i_result,
    output logic                     o_can_load,
    output logic                     o_valid,
    input  wire logic                i_stall,
    output spmc_pkg::t_out_item      o_item
);
    import spmc_pkg::*;

    logic      r_valid;
    t_out_item r_item;

    // A new result may enter when the register is empty or being drained.
    assign o_can_load = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_can_load && i_load) begin
            r_item <= i_result;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

// ===== hw/rtl/signal_pending_mask_controller_core.sv =====
// Pending/blocked signal controller for one task.
// Input channel: i_in_valid, o_in_stall, i_in_item (command, signal number,
// mask value, mask operation, consume flag, sleeping flag). A transfer happens
// at a rising edge with valid high and stall low.
// Output channel: o_out_valid, i_out_stall, o_out_item. Every command gives
// exactly one result, in command order.
// The item is captured in an input register, then the command executes against
// the state registers and its result is written to the output register, from
// where it is offered until transferred.
// Throughput is one item per cycle while i_out_stall is low, set by the single
// execute step that reads and updates the pending, blocked and wait registers.
// When the receiver stalls, the output register holds its result, the input
// register fills, and o_in_stall rises once both are occupied.
// i_cfg_we with i_cfg_wdata writes the allowed mask; write it only
// while no items are in flight.
// Synchronous reset (i_rst_n low) empties both registers, clears all
// controller state and sets the allowed mask to all signals above zero.
`default_nettype none

module signal_pending_mask_controller_core (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [31:0]        i_cfg_wdata,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire spmc_pkg::t_in_item i_in_item,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output spmc_pkg::t_out_item     o_out_item
);
    import spmc_pkg::*;

    logic      stg_valid;
    t_in_item  stg_item;
    logic      out_can_load;
    logic      fire;
    t_out_item exec_result;

    // An item executes when it is present and the result register can take it.
    assign fire = stg_valid && out_can_load;

    spmc_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_item  (i_in_item),
        .i_take  (out_can_load),
        .o_valid (stg_valid),
        .o_item  (stg_item)
    );

    spmc_exec u_exec (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_fire      (fire),
        .i_item      (stg_item),
        .o_result    (exec_result)
    );

    spmc_out_stage u_out_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (stg_valid),
        .i_result   (exec_result),
        .o_can_load (out_can_load),
        .o_valid    (o_out_valid),
        .i_stall    (i_out_stall),
        .o_item     (o_out_item)
    );

endmodule

`default_nettype wire
